/* rtl/vesp_pkg.sv */
package vesp_pkg;

    localparam int COORD_BITS = 21;
    localparam int PORT_W     = 63;

    localparam int DB    = COORD_BITS + 1;
    localparam int MB    = 2 * DB;
    localparam int NW    = MB + 1;
    localparam int POS_W = $clog2(MB);

    localparam int SH_W       = 30;
    localparam int SQ_W       = 2 * SH_W + 2;
    localparam int RT_W       = SH_W + 1;
    localparam int SQRT_STEPS = SQ_W / 2;

    localparam int UNIT_BITS = 16;
    localparam int QW        = UNIT_BITS + 1;
    localparam int UW        = UNIT_BITS + 2;
    localparam int DIV_STEPS = UNIT_BITS + 1;
    localparam int DV_W      = RT_W + UNIT_BITS;
    localparam int UNIT_LAT  = 5 + SQRT_STEPS + DIV_STEPS + 1;

    localparam int SW   = UW + 1;
    localparam int UD_W = 2 * UW + 2;
    localparam int MW   = SW + DB + 1;
    localparam int ND_W = MW + DB + 2;

    localparam int T_BITS = 24;
    localparam int TW     = T_BITS + 1;
    localparam int LP_W   = DB + TW;

    localparam logic [TW-1:0] T_HALF = {2'b01, {(T_BITS - 1){1'b0}}};
    localparam logic [TW-1:0] T_LOW  = TW'(838860);
    localparam logic [TW-1:0] T_HIGH = TW'(15938355);

    localparam int PIPE_LAT = 14 + UNIT_LAT + T_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DB-1:0]         diff_t;
    typedef logic signed [MB-1:0]         prod_t;
    typedef logic signed [NW-1:0]         norm_t;
    typedef logic signed [UW-1:0]         unit_t;

    typedef struct packed {
        logic [3*DB-1:0]         ed;
        logic [3*DB-1:0]         w;
        logic [3*DB-1:0]         dir;
        logic [3*COORD_BITS-1:0] p1;
    } side_t;

    function automatic coord_t coord_at(input logic [PORT_W-1:0] p, input int i);
        return $signed(p[i*COORD_BITS +: COORD_BITS]);
    endfunction

    function automatic coord_t coord3_at(input logic [3*COORD_BITS-1:0] p, input int i);
        return $signed(p[i*COORD_BITS +: COORD_BITS]);
    endfunction

    function automatic diff_t diff_at(input logic [3*DB-1:0] v, input int i);
        return $signed(v[i*DB +: DB]);
    endfunction

endpackage

/* rtl/vesp_unit.sv */
module vesp_unit
    import vesp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  norm_t n [3],
    output logic  out_valid,
    output unit_t u [3]
);

    logic              v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, ov_reg;
    logic [MB-1:0]     mag1_reg [3];
    logic [MB-1:0]     mag2_reg [3];
    logic [2:0]        sgn1_reg, sgn2_reg, sgn3_reg, sgn4_reg, sgn5_reg;
    logic [POS_W-1:0]  pos2_reg;
    logic              zero2_reg, zero3_reg, zero4_reg, zero5_reg;
    logic [SH_W-1:0]   sh3_reg [3];
    logic [SH_W-1:0]   sh4_reg [3];
    logic [SH_W-1:0]   sh5_reg [3];
    logic [2*SH_W-1:0] sqr4_reg [3];
    logic [SQ_W-1:0]   sum5_reg;
    unit_t             u_reg [3];

    logic [NW-1:0]       abs_c [3];
    logic [MB-1:0]       or_c;
    logic [POS_W-1:0]    pos_c;
    logic [MB+SH_W-1:0]  wide_c [3];

    logic              sqval_reg [SQRT_STEPS];
    logic [SQ_W-1:0]   sqv_reg [SQRT_STEPS];
    logic [SQ_W:0]     sqr_reg [SQRT_STEPS];
    logic [SH_W-1:0]   sqsh_reg [SQRT_STEPS][3];
    logic [2:0]        sqsg_reg [SQRT_STEPS];
    logic              sqz_reg [SQRT_STEPS];

    logic              dval_reg [DIV_STEPS];
    logic [DV_W-1:0]   drem_reg [DIV_STEPS][3];
    logic [QW-1:0]     dq_reg [DIV_STEPS][3];
    logic [RT_W-1:0]   dlen_reg [DIV_STEPS];
    logic [2:0]        dsg_reg [DIV_STEPS];
    logic              dz_reg [DIV_STEPS];

    always_comb
    begin
        or_c = '0;
        for (int i = 0; i < 3; i++)
        begin
            abs_c[i] = n[i][NW-1] ? NW'(-n[i]) : NW'(n[i]);
            or_c = or_c | mag1_reg[i];
        end
        pos_c = '0;
        for (int i = 0; i < MB; i++)
        begin
            if (or_c[i])
            begin
                pos_c = POS_W'(i);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (pos2_reg > POS_W'(SH_W - 1))
            begin
                wide_c[i] = (MB+SH_W)'(mag2_reg[i]) >> (pos2_reg - POS_W'(SH_W - 1));
            end
            else
            begin
                wide_c[i] = (MB+SH_W)'(mag2_reg[i]) << (POS_W'(SH_W - 1) - pos2_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            ov_reg <= dval_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag1_reg[i] <= abs_c[i][MB-1:0];
            sgn1_reg[i] <= n[i][NW-1];
            mag2_reg[i] <= mag1_reg[i];
            sh3_reg[i]  <= wide_c[i][SH_W-1:0];
            sh4_reg[i]  <= sh3_reg[i];
            sqr4_reg[i] <= sh3_reg[i] * sh3_reg[i];
            sh5_reg[i]  <= sh4_reg[i];
        end
        sgn2_reg  <= sgn1_reg;
        pos2_reg  <= pos_c;
        zero2_reg <= (or_c == '0);
        sgn3_reg  <= sgn2_reg;
        zero3_reg <= zero2_reg;
        sgn4_reg  <= sgn3_reg;
        zero4_reg <= zero3_reg;
        sum5_reg  <= SQ_W'(sqr4_reg[0]) + SQ_W'(sqr4_reg[1]) + SQ_W'(sqr4_reg[2]);
        sgn5_reg  <= sgn4_reg;
        zero5_reg <= zero4_reg;
    end

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        logic            vl_in;
        logic [SQ_W-1:0] v_in;
        logic [SQ_W:0]   r_in;
        logic [SH_W-1:0] sh_in [3];
        logic [2:0]      sg_in;
        logic            z_in;
        logic [SQ_W:0]   bit_c;
        logic [SQ_W:0]   t_c;
        logic [SQ_W-1:0] v_next;
        logic [SQ_W:0]   r_next;

        if (s == 0)
        begin : g_first
            assign vl_in = v5_reg;
            assign v_in  = sum5_reg;
            assign r_in  = '0;
            assign sh_in = sh5_reg;
            assign sg_in = sgn5_reg;
            assign z_in  = zero5_reg;
        end
        else
        begin : g_rest
            assign vl_in = sqval_reg[s-1];
            assign v_in  = sqv_reg[s-1];
            assign r_in  = sqr_reg[s-1];
            assign sh_in = sqsh_reg[s-1];
            assign sg_in = sqsg_reg[s-1];
            assign z_in  = sqz_reg[s-1];
        end

        assign bit_c = (SQ_W+1)'(1) << (SQ_W - 2 - 2 * s);

        always_comb
        begin
            t_c = r_in + bit_c;
            if ({1'b0, v_in} >= t_c)
            begin
                v_next = v_in - t_c[SQ_W-1:0];
                r_next = (r_in >> 1) + bit_c;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqval_reg[s] <= 1'b0;
            end
            else
            begin
                sqval_reg[s] <= vl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sqv_reg[s]  <= v_next;
            sqr_reg[s]  <= r_next;
            sqsh_reg[s] <= sh_in;
            sqsg_reg[s] <= sg_in;
            sqz_reg[s]  <= z_in;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic            vl_in;
        logic [DV_W-1:0] rem_in [3];
        logic [QW-1:0]   q_in [3];
        logic [RT_W-1:0] len_in;
        logic [2:0]      sg_in;
        logic            z_in;
        logic [DV_W:0]   lsh_c;
        logic [DV_W-1:0] rem_next [3];
        logic [QW-1:0]   q_next [3];

        if (j == 0)
        begin : g_first
            assign vl_in  = sqval_reg[SQRT_STEPS-1];
            assign len_in = sqr_reg[SQRT_STEPS-1][RT_W-1:0];
            assign sg_in  = sqsg_reg[SQRT_STEPS-1];
            assign z_in   = sqz_reg[SQRT_STEPS-1];
            for (genvar i = 0; i < 3; i++)
            begin : g_c
                assign rem_in[i] = DV_W'(sqsh_reg[SQRT_STEPS-1][i]) << UNIT_BITS;
                assign q_in[i]   = '0;
            end
        end
        else
        begin : g_rest
            assign vl_in  = dval_reg[j-1];
            assign len_in = dlen_reg[j-1];
            assign sg_in  = dsg_reg[j-1];
            assign z_in   = dz_reg[j-1];
            assign rem_in = drem_reg[j-1];
            assign q_in   = dq_reg[j-1];
        end

        assign lsh_c = (DV_W+1)'(len_in) << (UNIT_BITS - j);

        always_comb
        begin
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, rem_in[i]} >= lsh_c)
                begin
                    rem_next[i] = rem_in[i] - lsh_c[DV_W-1:0];
                    q_next[i]   = q_in[i] | (QW'(1) << (UNIT_BITS - j));
                end
                else
                begin
                    rem_next[i] = rem_in[i];
                    q_next[i]   = q_in[i];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dval_reg[j] <= 1'b0;
            end
            else
            begin
                dval_reg[j] <= vl_in;
            end
        end

        always_ff @(posedge clk)
        begin
            drem_reg[j] <= rem_next;
            dq_reg[j]   <= q_next;
            dlen_reg[j] <= len_in;
            dsg_reg[j]  <= sg_in;
            dz_reg[j]   <= z_in;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dz_reg[DIV_STEPS-1])
            begin
                u_reg[i] <= '0;
            end
            else if (dsg_reg[DIV_STEPS-1][i])
            begin
                u_reg[i] <= -$signed(UW'(dq_reg[DIV_STEPS-1][i]));
            end
            else
            begin
                u_reg[i] <= $signed(UW'(dq_reg[DIV_STEPS-1][i]));
            end
        end
    end

    assign out_valid = ov_reg;
    assign u         = u_reg;

`ifndef ASSERT_OFF
    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !zero3_reg |-> (sh3_reg[0][SH_W-1] || sh3_reg[1][SH_W-1] || sh3_reg[2][SH_W-1]))
        else $error("normalized magnitude out of range");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        sqval_reg[SQRT_STEPS-1] && !sqz_reg[SQRT_STEPS-1]
        |-> (sqr_reg[SQRT_STEPS-1][SH_W-1] || sqr_reg[SQRT_STEPS-1][SH_W]))
        else $error("root below normalized range");

    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        dval_reg[DIV_STEPS-1] && !dz_reg[DIV_STEPS-1]
        |-> (dq_reg[DIV_STEPS-1][0] <= (QW'(1) << UNIT_BITS))
            && (dq_reg[DIV_STEPS-1][1] <= (QW'(1) << UNIT_BITS))
            && (dq_reg[DIV_STEPS-1][2] <= (QW'(1) << UNIT_BITS)))
        else $error("unit component above one");
`endif

endmodule

/* rtl/voronoi_edge_split_point.sv */
// Splits a segment where it crosses the bisecting plane of two triangles that share an edge.
// A transfer is taken on every cycle that start is high; busy stays low, so items may follow
// back to back. Each result appears on split_point and used_midpoint for one cycle with done
// high and cannot be held off. Most of the pipeline lies in the square-root and division
// pipelines of the normal units (one result bit per stage) and in the 24-stage divider that
// forms the plane parameter.
module voronoi_edge_split_point
    import vesp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [PORT_W-1:0] tri1_a,
    input  logic [PORT_W-1:0] tri1_b,
    input  logic [PORT_W-1:0] tri1_c,
    input  logic [PORT_W-1:0] tri2_a,
    input  logic [PORT_W-1:0] tri2_b,
    input  logic [PORT_W-1:0] tri2_c,
    input  logic [PORT_W-1:0] edge_start,
    input  logic [PORT_W-1:0] edge_end,
    input  logic [PORT_W-1:0] seg_start,
    input  logic [PORT_W-1:0] seg_end,
    output logic              done,
    output logic [PORT_W-1:0] split_point,
    output logic              used_midpoint
);

    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg, vg_reg;
    logic vh_reg, vi_reg, vj_reg, vk_reg, vl_reg, vm_reg, done_reg;

    diff_t ca1_reg [3], ba1_reg [3], ca2_reg [3], ba2_reg [3];
    side_t sa_reg, sb_reg, sc_reg, sdd_reg, se_reg, sf_reg, sg_reg, sh_reg;
    side_t si_reg, sj_reg, sk_reg;
    prod_t pa1_reg [3], pb1_reg [3], pa2_reg [3], pb2_reg [3];
    norm_t n1_reg [3], n2_reg [3];

    side_t sd_reg [UNIT_LAT];
    logic  sdv_reg [UNIT_LAT];

    logic  u1_valid, u2_valid;
    unit_t u1 [3], u2 [3];

    logic signed [2*UW-1:0] dp_reg [3];
    unit_t                  u1d_reg [3], u2d_reg [3];
    logic signed [UD_W-1:0] dot_c;
    logic signed [SW-1:0]   s_c [3];
    logic signed [SW-1:0]   s_reg [3];
    logic signed [MW-2:0]   fa_reg [3], fb_reg [3];
    logic signed [MW-1:0]   m_reg [3];
    logic signed [MW+DB-1:0] hn_reg [3], hd_reg [3];
    logic signed [ND_W-1:0] num_reg, den_reg, jn_reg, jd_reg;
    logic [ND_W-1:0]        kr_reg, kd_reg;
    logic                   kmid_reg;

    logic                   tv_reg [T_BITS];
    logic [ND_W-1:0]        tr_reg [T_BITS];
    logic [ND_W-1:0]        td_reg [T_BITS];
    logic [T_BITS-1:0]      tq_reg [T_BITS];
    logic                   tmid_reg [T_BITS];
    side_t                  ts_reg [T_BITS];

    logic                   lmid_reg;
    logic [TW-1:0]          ltsel_reg;
    side_t                  ls_reg;
    logic [LP_W-1:0]        mprod_reg [3];
    logic [2:0]             mneg_reg;
    logic                   mmid_reg;
    logic [3*COORD_BITS-1:0] mp1_reg;

    logic [PORT_W-1:0]      split_point_reg, split_point_next;
    logic                   used_midpoint_reg;
    logic                   lmid_next;
    logic [LP_W-1:0]        rnd_c [3];
    logic signed [DB:0]     q_c [3];
    logic signed [DB:0]     res_c [3];
    logic [DB-1:0]          mag_c [3];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
            ve_reg   <= 1'b0;
            vf_reg   <= 1'b0;
            vg_reg   <= 1'b0;
            vh_reg   <= 1'b0;
            vi_reg   <= 1'b0;
            vj_reg   <= 1'b0;
            vk_reg   <= 1'b0;
            vl_reg   <= 1'b0;
            vm_reg   <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < UNIT_LAT; i++)
            begin
                sdv_reg[i] <= 1'b0;
            end
            for (int i = 0; i < T_BITS; i++)
            begin
                tv_reg[i] <= 1'b0;
            end
        end
        else
        begin
            va_reg     <= start && !busy;
            vb_reg     <= va_reg;
            vc_reg     <= vb_reg;
            sdv_reg[0] <= vc_reg;
            for (int i = 1; i < UNIT_LAT; i++)
            begin
                sdv_reg[i] <= sdv_reg[i-1];
            end
            vd_reg    <= u1_valid;
            ve_reg    <= vd_reg;
            vf_reg    <= ve_reg;
            vg_reg    <= vf_reg;
            vh_reg    <= vg_reg;
            vi_reg    <= vh_reg;
            vj_reg    <= vi_reg;
            vk_reg    <= vj_reg;
            tv_reg[0] <= vk_reg;
            for (int i = 1; i < T_BITS; i++)
            begin
                tv_reg[i] <= tv_reg[i-1];
            end
            vl_reg   <= tv_reg[T_BITS-1];
            vm_reg   <= vl_reg;
            done_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ca1_reg[i] <= diff_t'(coord_at(tri1_c, i)) - diff_t'(coord_at(tri1_a, i));
            ba1_reg[i] <= diff_t'(coord_at(tri1_b, i)) - diff_t'(coord_at(tri1_a, i));
            ca2_reg[i] <= diff_t'(coord_at(tri2_c, i)) - diff_t'(coord_at(tri2_a, i));
            ba2_reg[i] <= diff_t'(coord_at(tri2_b, i)) - diff_t'(coord_at(tri2_a, i));
            sa_reg.ed[i*DB +: DB] <= diff_t'(coord_at(edge_start, i))
                                   - diff_t'(coord_at(edge_end, i));
            sa_reg.w[i*DB +: DB] <= diff_t'(coord_at(edge_start, i))
                                  - diff_t'(coord_at(seg_start, i));
            sa_reg.dir[i*DB +: DB] <= diff_t'(coord_at(seg_end, i))
                                    - diff_t'(coord_at(seg_start, i));
            sa_reg.p1[i*COORD_BITS +: COORD_BITS] <= coord_at(seg_start, i);

            pa1_reg[i] <= ca1_reg[(i+1)%3] * ba1_reg[(i+2)%3];
            pb1_reg[i] <= ca1_reg[(i+2)%3] * ba1_reg[(i+1)%3];
            pa2_reg[i] <= ca2_reg[(i+1)%3] * ba2_reg[(i+2)%3];
            pb2_reg[i] <= ca2_reg[(i+2)%3] * ba2_reg[(i+1)%3];

            n1_reg[i] <= norm_t'(pa1_reg[i]) - norm_t'(pb1_reg[i]);
            n2_reg[i] <= norm_t'(pa2_reg[i]) - norm_t'(pb2_reg[i]);
        end
        sb_reg <= sa_reg;
        sc_reg <= sb_reg;
        sd_reg[0] <= sc_reg;
        for (int i = 1; i < UNIT_LAT; i++)
        begin
            sd_reg[i] <= sd_reg[i-1];
        end
    end

    vesp_unit u_unit1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .n         (n1_reg),
        .out_valid (u1_valid),
        .u         (u1)
    );

    vesp_unit u_unit2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .n         (n2_reg),
        .out_valid (u2_valid),
        .u         (u2)
    );

    always_comb
    begin
        dot_c = UD_W'(dp_reg[0]) + UD_W'(dp_reg[1]) + UD_W'(dp_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            if (dot_c < 0)
            begin
                s_c[i] = SW'(u1d_reg[i]) - SW'(u2d_reg[i]);
            end
            else
            begin
                s_c[i] = SW'(u1d_reg[i]) + SW'(u2d_reg[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp_reg[i]  <= u1[i] * u2[i];
            u1d_reg[i] <= u1[i];
            u2d_reg[i] <= u2[i];
            s_reg[i]   <= s_c[i];
            fa_reg[i]  <= s_reg[(i+1)%3] * diff_at(se_reg.ed, (i+2)%3);
            fb_reg[i]  <= s_reg[(i+2)%3] * diff_at(se_reg.ed, (i+1)%3);
            m_reg[i]   <= MW'(fa_reg[i]) - MW'(fb_reg[i]);
            hn_reg[i]  <= m_reg[i] * diff_at(sg_reg.w, i);
            hd_reg[i]  <= m_reg[i] * diff_at(sg_reg.dir, i);
        end
        sdd_reg <= sd_reg[UNIT_LAT-1];
        se_reg  <= sdd_reg;
        sf_reg  <= se_reg;
        sg_reg  <= sf_reg;
        sh_reg  <= sg_reg;
        si_reg  <= sh_reg;
        sj_reg  <= si_reg;
        sk_reg  <= sj_reg;
        num_reg <= ND_W'(hn_reg[0]) + ND_W'(hn_reg[1]) + ND_W'(hn_reg[2]);
        den_reg <= ND_W'(hd_reg[0]) + ND_W'(hd_reg[1]) + ND_W'(hd_reg[2]);
        if (den_reg < 0)
        begin
            jn_reg <= -num_reg;
            jd_reg <= -den_reg;
        end
        else
        begin
            jn_reg <= num_reg;
            jd_reg <= den_reg;
        end
        kmid_reg <= (jd_reg == 0) || (jn_reg <= 0) || (jn_reg >= jd_reg);
        if ((jd_reg == 0) || (jn_reg <= 0) || (jn_reg >= jd_reg))
        begin
            kr_reg <= '0;
        end
        else
        begin
            kr_reg <= jn_reg;
        end
        kd_reg <= jd_reg;
    end

    for (genvar j = 0; j < T_BITS; j++)
    begin : g_tdiv
        logic [ND_W-1:0]   r_in;
        logic [ND_W-1:0]   d_in;
        logic [T_BITS-1:0] q_in;
        logic              mid_in;
        side_t             s_in;
        logic [ND_W:0]     r2_c;
        logic [ND_W-1:0]   r_next;
        logic [T_BITS-1:0] q_next;

        if (j == 0)
        begin : g_first
            assign r_in   = kr_reg;
            assign d_in   = kd_reg;
            assign q_in   = '0;
            assign mid_in = kmid_reg;
            assign s_in   = sk_reg;
        end
        else
        begin : g_rest
            assign r_in   = tr_reg[j-1];
            assign d_in   = td_reg[j-1];
            assign q_in   = tq_reg[j-1];
            assign mid_in = tmid_reg[j-1];
            assign s_in   = ts_reg[j-1];
        end

        always_comb
        begin
            r2_c = {r_in, 1'b0};
            if (r2_c >= {1'b0, d_in})
            begin
                r_next = r2_c[ND_W-1:0] - d_in;
                q_next = {q_in[T_BITS-2:0], 1'b1};
            end
            else
            begin
                r_next = r2_c[ND_W-1:0];
                q_next = {q_in[T_BITS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            tr_reg[j]   <= r_next;
            td_reg[j]   <= d_in;
            tq_reg[j]   <= q_next;
            tmid_reg[j] <= mid_in;
            ts_reg[j]   <= s_in;
        end
    end

    always_comb
    begin
        lmid_next = tmid_reg[T_BITS-1]
                 || ({1'b0, tq_reg[T_BITS-1]} <= T_LOW)
                 || ({1'b0, tq_reg[T_BITS-1]} >= T_HIGH);
        for (int i = 0; i < 3; i++)
        begin
            if (diff_at(ls_reg.dir, i) < 0)
            begin
                mag_c[i] = DB'(-diff_at(ls_reg.dir, i));
            end
            else
            begin
                mag_c[i] = DB'(diff_at(ls_reg.dir, i));
            end
            rnd_c[i] = (mprod_reg[i] + LP_W'(T_HALF)) >> T_BITS;
            q_c[i]   = $signed({1'b0, rnd_c[i][DB-1:0]});
            if (mneg_reg[i])
            begin
                res_c[i] = (DB+1)'(coord3_at(mp1_reg, i)) - q_c[i];
            end
            else
            begin
                res_c[i] = (DB+1)'(coord3_at(mp1_reg, i)) + q_c[i];
            end
        end
        split_point_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            split_point_next[i*COORD_BITS +: COORD_BITS] = res_c[i][COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        lmid_reg <= lmid_next;
        if (lmid_next)
        begin
            ltsel_reg <= T_HALF;
        end
        else
        begin
            ltsel_reg <= {1'b0, tq_reg[T_BITS-1]};
        end
        ls_reg <= ts_reg[T_BITS-1];
        for (int i = 0; i < 3; i++)
        begin
            mprod_reg[i] <= LP_W'(mag_c[i]) * LP_W'(ltsel_reg);
            mneg_reg[i]  <= ls_reg.dir[i*DB + DB - 1];
        end
        mmid_reg          <= lmid_reg;
        mp1_reg           <= ls_reg.p1;
        split_point_reg   <= split_point_next;
        used_midpoint_reg <= mmid_reg;
    end

    assign done          = done_reg;
    assign split_point   = split_point_reg;
    assign used_midpoint = used_midpoint_reg;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_LAT done)
        else $error("result strobe missing after fixed latency");

    a_unit_align: assert property (@(posedge clk) disable iff (!rst_n)
        (u1_valid == sdv_reg[UNIT_LAT-1]) && (u2_valid == sdv_reg[UNIT_LAT-1]))
        else $error("normal units out of step with side data");

    a_t_select: assert property (@(posedge clk) disable iff (!rst_n)
        vm_reg |-> (mmid_reg ? ($past(ltsel_reg) == T_HALF)
                             : (($past(ltsel_reg) > T_LOW) && ($past(ltsel_reg) < T_HIGH))))
        else $error("plane parameter outside its window");
`endif

endmodule

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import vesp_pkg::*;

    localparam longint T_ONE_HALF = 64'd1 << 23;

    typedef struct {
        logic [PORT_W-1:0] point;
        logic              mid;
    } split_t;

    class split_scoreboard;
        split_t pending[$];
        int     errors = 0;

        function longint coord(logic [PORT_W-1:0] w, int i);
            coord_t c;
            c = coord_at(w, i);
            return longint'(c);
        endfunction

        function longint unsigned mag(longint v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        function longint unsigned root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void normalize(longint n[3], output longint u[3]);
            longint unsigned m[3], mx, len;
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = mag(n[i]);
                if (m[i] > mx) mx = m[i];
            end
            if (mx == 0)
            begin
                for (int i = 0; i < 3; i++) u[i] = 0;
                return;
            end
            while (mx >= (64'd1 << 30))
            begin
                mx = mx >> 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
            end
            while (mx < (64'd1 << 29))
            begin
                mx = mx << 1;
                for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
            end
            len = root(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
            for (int i = 0; i < 3; i++)
            begin
                longint q;
                q = longint'((m[i] << 16) / len);
                u[i] = n[i] < 0 ? -q : q;
            end
        endfunction

        function void face_normal(logic [PORT_W-1:0] a, logic [PORT_W-1:0] b,
                                  logic [PORT_W-1:0] c, output longint u[3]);
            longint ca[3], ba[3], n[3];
            for (int i = 0; i < 3; i++)
            begin
                ca[i] = coord(c, i) - coord(a, i);
                ba[i] = coord(b, i) - coord(a, i);
            end
            n[0] = ca[1] * ba[2] - ca[2] * ba[1];
            n[1] = ca[2] * ba[0] - ca[0] * ba[2];
            n[2] = ca[0] * ba[1] - ca[1] * ba[0];
            normalize(n, u);
        endfunction

        function void note_transfer(logic [PORT_W-1:0] v[10]);
            longint u1[3], u2[3], s[3], ed[3], m[3], dir[3], w[3];
            longint num, den, t, off;
            longint unsigned r, d, q;
            split_t e;
            face_normal(v[0], v[1], v[2], u1);
            face_normal(v[3], v[4], v[5], u2);
            if (u1[0] * u2[0] + u1[1] * u2[1] + u1[2] * u2[2] < 0)
                for (int i = 0; i < 3; i++) u2[i] = -u2[i];
            for (int i = 0; i < 3; i++)
            begin
                s[i] = u1[i] + u2[i];
                ed[i] = coord(v[6], i) - coord(v[7], i);
                dir[i] = coord(v[9], i) - coord(v[8], i);
                w[i] = coord(v[6], i) - coord(v[8], i);
            end
            m[0] = s[1] * ed[2] - s[2] * ed[1];
            m[1] = s[2] * ed[0] - s[0] * ed[2];
            m[2] = s[0] * ed[1] - s[1] * ed[0];
            num = m[0] * w[0] + m[1] * w[1] + m[2] * w[2];
            den = m[0] * dir[0] + m[1] * dir[1] + m[2] * dir[2];
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            e.mid = 1'b0;
            if (den == 0 || num <= 0 || num >= den)
                e.mid = 1'b1;
            else
            begin
                r = num;
                d = den;
                q = 0;
                for (int i = 0; i < 24; i++)
                begin
                    r = r << 1;
                    q = q << 1;
                    if (r >= d)
                    begin
                        r = r - d;
                        q = q | 1;
                    end
                end
                t = longint'(q);
                if (t <= 838860 || t >= 15938355) e.mid = 1'b1;
            end
            if (e.mid) t = T_ONE_HALF;
            e.point = '0;
            for (int i = 0; i < 3; i++)
            begin
                q = (mag(dir[i]) * longint'(t) + T_ONE_HALF) >> 24;
                off = dir[i] < 0 ? -longint'(q) : longint'(q);
                e.point[i*COORD_BITS +: COORD_BITS] = coord_t'(coord(v[8], i) + off);
            end
            pending.push_back(e);
        endfunction

        function void check_result(logic [PORT_W-1:0] point, logic mid);
            split_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected: point %h mid %b", $time, point, mid);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (point !== e.point)
            begin
                $display("%0t: split_point expected %h actual %h", $time, e.point, point);
                errors++;
            end
            if (mid !== e.mid)
            begin
                $display("%0t: used_midpoint expected %b actual %b", $time, e.mid, mid);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [PORT_W-1:0] pin[10];
    logic              done;
    logic [PORT_W-1:0] split_point;
    logic              used_midpoint;
    split_scoreboard   sb = new();

    initial
        for (int i = 0; i < 10; i++) pin[i] = '0;

    always #6 clk = ~clk;

    voronoi_edge_split_point dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .tri1_a(pin[0]), .tri1_b(pin[1]), .tri1_c(pin[2]),
        .tri2_a(pin[3]), .tri2_b(pin[4]), .tri2_c(pin[5]),
        .edge_start(pin[6]), .edge_end(pin[7]),
        .seg_start(pin[8]), .seg_end(pin[9]),
        .done(done), .split_point(split_point), .used_midpoint(used_midpoint)
    );

    always @(posedge clk)
        if (rst_n && done) sb.check_result(split_point, used_midpoint);

    function automatic logic [PORT_W-1:0] pt(int x, int y, int z);
        return {z[COORD_BITS-1:0], y[COORD_BITS-1:0], x[COORD_BITS-1:0]};
    endfunction

    function automatic int rc(int r);
        return int'($urandom_range(0, 2 << r)) - (1 << r);
    endfunction

    function automatic logic [PORT_W-1:0] rpt(int r);
        return pt(rc(r), rc(r), rc(r));
    endfunction

    task automatic send(logic [PORT_W-1:0] v[10]);
        for (int i = 0; i < 10; i++) pin[i] <= v[i];
        start <= 1'b1;
        do @(posedge clk); while (busy);
        sb.note_transfer(v);
    endtask

    task automatic gap(int pct);
        if ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic bisect_item(int r, int flat);
        logic [PORT_W-1:0] v[10];
        logic [PORT_W-1:0] e1, e2, c1, c2;
        e1 = rpt(r);
        e2 = rpt(r);
        c1 = rpt(r);
        c2 = flat ? c1 : rpt(r);
        v[0] = e1;
        v[1] = $urandom_range(0, 1) ? e2 : c1;
        v[2] = v[1] == e2 ? c1 : e2;
        v[3] = $urandom_range(0, 1) ? e1 : e2;
        v[4] = v[3] == e1 ? e2 : e1;
        v[5] = c2;
        v[6] = e1;
        v[7] = e2;
        v[8] = rpt(r);
        v[9] = $urandom_range(0, 9) == 0 ? v[8] : rpt(r);
        send(v);
    endtask

    task automatic noise_item();
        logic [PORT_W-1:0] v[10];
        for (int i = 0; i < 10; i++) v[i] = PORT_W'({$urandom, $urandom});
        send(v);
    endtask

    task automatic line_item(int x0, int x1);
        logic [PORT_W-1:0] v[10];
        int k;
        k = 4096;
        v[0] = pt(0, 0, 0); v[1] = pt(k, 0, 0); v[2] = pt(0, k, 0);
        v[3] = pt(0, 0, 0); v[4] = pt(k, 0, 0); v[5] = pt(0, 0, k);
        v[6] = pt(0, 0, 0); v[7] = pt(k, 0, 0);
        v[8] = pt(0, x0, -x0);
        v[9] = pt(0, x1, -x1);
        send(v);
    endtask

    task automatic const_item(logic [PORT_W-1:0] w);
        logic [PORT_W-1:0] v[10];
        for (int i = 0; i < 10; i++) v[i] = w;
        send(v);
    endtask

    initial
    begin
        int pct[3];
        pct = '{9, 69, 0};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        const_item('0);
        const_item('1);
        const_item(pt(1 << 20, 1 << 20, 1 << 20));
        const_item(pt((1 << 20) - 1, (1 << 20) - 1, (1 << 20) - 1));
        line_item(-1000, 1000);
        line_item(-40, 1000);
        line_item(-1000, 40);
        line_item(-52, 1000);
        line_item(-1000, 52);
        line_item(100, 1000);
        line_item(0, 1000);
        line_item(-(1 << 19), (1 << 19) - 1);
        line_item(500, 500);
        bisect_item(19, 0);
        bisect_item(19, 1);
        bisect_item(3, 0);
        noise_item();
        noise_item();
        drain();

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int n = 0; n < 245; n++)
            begin
                if ($urandom_range(0, 99) < 75)
                    bisect_item($urandom_range(2, 19), $urandom_range(0, 19) == 0);
                else
                    noise_item();
                gap(pct[ph]);
            end
            drain();
        end

        repeat (120) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
